/* rtl/core/nfa_pkg.sv */
package nfa_pkg;

    localparam int unsigned REQ_TYPE_W   = 2;
    localparam int unsigned ADDRESS_W    = 16;
    localparam int unsigned BYTE_W       = 8;

    typedef logic [REQ_TYPE_W-1:0] t_req_type;
    typedef logic [ADDRESS_W-1:0]  t_address;
    typedef logic [BYTE_W-1:0]     t_byte;

    localparam t_req_type REQ_READ         = 2'd0;
    localparam t_req_type REQ_PROGRAM      = 2'd1;
    localparam t_req_type REQ_SECTOR_ERASE = 2'd2;
    localparam t_req_type REQ_CHIP_ERASE   = 2'd3;

    localparam t_byte ERASED_BYTE = 8'hFF;

endpackage

/* rtl/core/nfa_req_if.sv */
interface nfa_req_if
    import nfa_pkg::*;
();
    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_address  address;
    t_byte     wr_data;
    logic      burst_last;

    modport source (output valid, output req_type, output address, output wr_data,
                    output burst_last, input ready);
    modport sink   (input valid, input req_type, input address, input wr_data,
                    input burst_last, output ready);
endinterface

/* rtl/core/nfa_rsp_if.sv */
interface nfa_rsp_if
    import nfa_pkg::*;
();
    logic      valid;
    logic      ready;
    t_byte     rd_data;
    t_req_type done_type;

    modport source (output valid, output rd_data, output done_type, input ready);
    modport sink   (input valid, input rd_data, input done_type, output ready);
endinterface

/* rtl/core/nor_flash_array_model.sv */
// NOR flash byte array.
// Requests arrive on i_req (valid/ready): byte read, byte program, sector
// erase or chip erase. Each request gives exactly one response on o_rsp,
// carrying the read byte (zero for non-reads) and the echoed request type.
// Reads and programs run as bursts: the first request of a burst uses its
// address, later ones follow an internal pointer. Read bursts wrap at the
// end of memory, program bursts wrap within the page where the burst began.
// One request is handled at a time through a single-port byte RAM:
//   read    : the RAM read is registered, then the response register is loaded
//   program : response registered in the cycle after accept
//   erase   : one byte is written per cycle; a sector erase clears
//             min(SECTOR_BYTES, MEM_BYTES) bytes and a chip erase
//             MEM_BYTES bytes
// i_req.ready is high only while idle with the response register empty.
// After reset the array is swept to 0xFF, one byte per cycle; no request is
// taken meanwhile.
// A stalled response holds in its register until taken; no new request is
// accepted until then. Sizes must be powers of two; the block does not enforce it.
module nor_flash_array_model
    import nfa_pkg::*;
#(
    parameter int unsigned MEM_BYTES    = 65536,
    parameter int unsigned PAGE_BYTES   = 256,
    parameter int unsigned SECTOR_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nfa_req_if.sink    i_req,
    nfa_rsp_if.source  o_rsp
);

    localparam int unsigned AW      = $clog2(MEM_BYTES);
    localparam int unsigned PG_LEN  = (PAGE_BYTES < MEM_BYTES) ? PAGE_BYTES : MEM_BYTES;
    localparam int unsigned SEC_LEN = (SECTOR_BYTES < MEM_BYTES) ? SECTOR_BYTES : MEM_BYTES;

    localparam logic [AW-1:0] PG_MASK  = AW'(PG_LEN - 1);
    localparam logic [AW-1:0] SEC_MASK = AW'(SEC_LEN - 1);
    localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_ERASE = 3'd3;

    logic [2:0]      r_state, n_state;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_pbase, n_pbase;
    logic            r_burst, n_burst;
    logic [AW-1:0]   r_sweep, n_sweep;
    logic [AW-1:0]   r_sweep_end, n_sweep_end;
    logic            r_out_valid, n_out_valid;
    t_byte           r_out_data, n_out_data;
    t_req_type       r_out_type, n_out_type;

    logic            w_accept;
    logic [31:0]     w_addr_ext;
    logic [AW-1:0]   w_addr;
    logic [AW-1:0]   w_ptr;
    logic [AW-1:0]   w_pbase;
    logic [31:0]     w_nxt;
    logic [31:0]     w_page_end;
    logic [AW-1:0]   w_sec_start;

    logic            w_ram_we;
    logic [AW-1:0]   w_ram_addr;
    t_byte           w_ram_wdata;
    t_byte           w_ram_rdata;

    nfa_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_addr_ext  = {16'b0, i_req.address};
    assign w_addr      = w_addr_ext[AW-1:0];
    assign w_ptr       = r_burst ? r_ptr   : w_addr;
    assign w_pbase     = r_burst ? r_pbase : (w_addr & ~PG_MASK);
    assign w_nxt       = 32'(w_ptr) + 32'd1;
    assign w_page_end  = 32'(w_pbase) + 32'(PAGE_BYTES);
    assign w_sec_start = w_addr & ~SEC_MASK;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pbase     = r_pbase;
        n_burst     = r_burst;
        n_sweep     = r_sweep;
        n_sweep_end = r_sweep_end;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_type  = r_out_type;
        w_ram_we    = 1'b0;
        w_ram_addr  = w_ptr;
        w_ram_wdata = i_req.wr_data;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR, ST_ERASE: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_sweep;
                w_ram_wdata = ERASED_BYTE;
                n_sweep     = r_sweep + AW'(1);
                if (r_sweep == r_sweep_end) begin
                    n_state = ST_IDLE;
                    if (r_state == ST_ERASE) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_data  = w_ram_rdata;
                n_state     = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_type = i_req.req_type;
                    n_out_data = '0;
                    case (i_req.req_type)
                        REQ_READ: begin
                            n_pbase = w_pbase;
                            n_burst = !i_req.burst_last;
                            n_ptr   = (w_nxt >= 32'(MEM_BYTES)) ? '0 : w_nxt[AW-1:0];
                            n_state = ST_READ;
                        end
                        REQ_PROGRAM: begin
                            w_ram_we    = 1'b1;
                            n_pbase     = w_pbase;
                            n_burst     = !i_req.burst_last;
                            // wrap inside the page where the burst started
                            if (w_nxt >= w_page_end || w_nxt >= 32'(MEM_BYTES)) begin
                                n_ptr = w_pbase;
                            end else begin
                                n_ptr = w_nxt[AW-1:0];
                            end
                            n_out_valid = 1'b1;
                        end
                        REQ_SECTOR_ERASE: begin
                            n_burst     = 1'b0;
                            n_sweep     = w_sec_start;
                            n_sweep_end = w_sec_start | SEC_MASK;
                            n_state     = ST_ERASE;
                        end
                        default: begin
                            n_burst     = 1'b0;
                            n_sweep     = '0;
                            n_sweep_end = MEM_LAST;
                            n_state     = ST_ERASE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_pbase     <= '0;
            r_burst     <= 1'b0;
            r_sweep     <= '0;
            r_sweep_end <= MEM_LAST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pbase     <= n_pbase;
            r_burst     <= n_burst;
            r_sweep     <= n_sweep;
            r_sweep_end <= n_sweep_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_type <= n_out_type;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.rd_data   = r_out_data;
    assign o_rsp.done_type = r_out_type;

endmodule

/* rtl/core/nfa_ram.sv */
module nfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* test/tb_nor_flash_array_model.sv */
`timescale 1ns / 1ps

import nfa_pkg::*;

// Tracks the flash contents and burst pointer, queues the response each request
// should produce, and compares responses as they come back.
class flash_scoreboard;
    localparam int unsigned FLASH_BYTES    = 65536;
    localparam int unsigned FLASH_PG_BYTES = 256;
    localparam int unsigned FLASH_SEC_BYTES = 4096;

    typedef struct packed {
        t_byte     rd_data;
        t_req_type done_type;
    } t_rsp;

    t_byte       flash [FLASH_BYTES];
    int unsigned next_addr;
    int unsigned page_start;
    bit          burst_open;
    t_rsp        pending_rsp [$];
    int          errors;
    int          n_read, n_program, n_sector, n_chip, n_page_wraps, n_read_wraps;

    function new();
        erase_range(0, FLASH_BYTES);
        next_addr  = 0;
        page_start = 0;
        burst_open = 1'b0;
    endfunction

    function void erase_range(int unsigned start, int unsigned len);
        for (int unsigned i = start; i < start + len; i++) begin
            flash[i] = ERASED_BYTE;
        end
    endfunction

    function int pending();
        return pending_rsp.size();
    endfunction

    function void note_request(t_req_type kind, t_address addr, t_byte data, bit last);
        t_rsp        rsp;
        int unsigned ptr;
        int unsigned nxt;
        int unsigned start;
        int unsigned len;
        rsp.rd_data   = '0;
        rsp.done_type = kind;
        case (kind)
            REQ_READ, REQ_PROGRAM: begin
                if (!burst_open) begin
                    next_addr  = addr % FLASH_BYTES;
                    page_start = next_addr - (next_addr % FLASH_PG_BYTES);
                end
                ptr = next_addr % FLASH_BYTES;
                nxt = ptr + 1;
                if (kind == REQ_READ) begin
                    rsp.rd_data = flash[ptr];
                    n_read++;
                    if (nxt >= FLASH_BYTES) begin
                        nxt = 0;
                        n_read_wraps++;
                    end
                end else begin
                    flash[ptr] = data;
                    n_program++;
                    // program bursts fold back to the page they started in
                    if (nxt >= page_start + FLASH_PG_BYTES || nxt >= FLASH_BYTES) begin
                        nxt = page_start;
                        n_page_wraps++;
                    end
                end
                next_addr  = nxt;
                burst_open = !last;
            end
            REQ_SECTOR_ERASE: begin
                start = (addr % FLASH_BYTES) - ((addr % FLASH_BYTES) % FLASH_SEC_BYTES);
                len   = FLASH_SEC_BYTES;
                if (len > FLASH_BYTES - start) len = FLASH_BYTES - start;
                erase_range(start, len);
                burst_open = 1'b0;
                n_sector++;
            end
            default: begin
                erase_range(0, FLASH_BYTES);
                burst_open = 1'b0;
                n_chip++;
            end
        endcase
        pending_rsp.push_back(rsp);
    endfunction

    function void check_response(t_byte rd, t_req_type kind);
        t_rsp exp_rsp;
        if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: rd_data=%h done_type=%0d", $time, rd, kind);
            return;
        end
        exp_rsp = pending_rsp.pop_front();
        if (exp_rsp.rd_data !== rd) begin
            errors++;
            $display("%0t: rd_data mismatch: expected %h, actual %h",
                     $time, exp_rsp.rd_data, rd);
        end
        if (exp_rsp.done_type !== kind) begin
            errors++;
            $display("%0t: done_type mismatch: expected %0d, actual %0d",
                     $time, exp_rsp.done_type, kind);
        end
    endfunction
endclass

module tb_nor_flash_array_model;

    localparam int unsigned MEM_BYTES    = 65536;
    localparam int unsigned PAGE_BYTES   = 256;
    localparam int unsigned SECTOR_BYTES = 4096;

    localparam int N_ITEMS     = 600;
    localparam int QUIET_FROM  = 520;
    localparam int SECTOR_CAP  = 40;
    localparam int CHIP_CAP    = 2;
    localparam int TAIL_CYCLES = 20;
    // reset sweep + 3 chip erases + capped sector erases + stalled byte requests,
    // taken several times over
    localparam int CYCLE_LIMIT = 3_000_000;

    logic i_clk;
    logic i_rst_n;

    nfa_req_if req_if ();
    nfa_rsp_if rsp_if ();

    nor_flash_array_model #(
        .MEM_BYTES    (MEM_BYTES),
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    flash_scoreboard sb;
    int              sent;
    int              cycles;
    int              stall_left;
    int              sector_count;
    int              chip_count;
    bit              quiet;
    bit              drained_mid;
    bit [7:0]        hot_page [4];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // response side back-pressure
    always @(posedge i_clk) begin
        if (quiet || i_rst_n !== 1'b1) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_response(rsp_if.rd_data, rsp_if.done_type);
    end

    task automatic send(t_req_type kind, t_address addr, t_byte data, bit last);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.address    <= addr;
        req_if.wr_data    <= data;
        req_if.burst_last <= last;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_request(kind, addr, data, last);
        sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_address pick_address();
        t_address a;
        case ($urandom_range(0, 9))
            0, 1, 2: a = t_address'($urandom);
            3:       a = {8'hFF, 8'($urandom)};
            default: a = {hot_page[$urandom_range(0, 3)], 8'($urandom)};
        endcase
        // start near a page end so program bursts fold back
        if ($urandom_range(0, 3) == 0) a[7:0] = 8'($urandom_range(240, 255));
        return a;
    endfunction

    // mixed: each item is a read or a program at random; open: no burst_last
    task automatic run_burst(t_req_type kind, bit mixed, bit open);
        t_req_type k;
        int        len;
        t_address  start;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        start = pick_address();
        for (int i = 0; i < len; i++) begin
            k = mixed ? ($urandom_range(0, 1) ? REQ_PROGRAM : REQ_READ) : kind;
            send(k, (i == 0) ? start : t_address'($urandom), t_byte'($urandom),
                 (i == len - 1) && !open);
        end
    endtask

    initial begin
        int sel;
        sb              = new();
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_READ;
        req_if.address  = '0;
        req_if.wr_data  = '0;
        req_if.burst_last = 1'b0;
        rsp_if.ready    = 1'b0;
        for (int i = 0; i < 4; i++) hot_page[i] = 8'($urandom);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single bytes, page fold, end-of-memory wraps
        send(REQ_READ,    16'h0000, 8'h00, 1'b1);
        send(REQ_PROGRAM, 16'h0000, 8'h00, 1'b1);
        send(REQ_READ,    16'h0000, 8'hFF, 1'b1);
        send(REQ_PROGRAM, 16'h12FE, 8'hA5, 1'b0);
        send(REQ_PROGRAM, 16'hFFFF, 8'h5A, 1'b0);
        send(REQ_PROGRAM, 16'h0000, 8'h3C, 1'b1);
        send(REQ_READ,    16'h12FF, 8'h00, 1'b0);
        send(REQ_READ,    16'h0000, 8'h00, 1'b1);
        send(REQ_READ,    16'hFFFF, 8'h00, 1'b0);
        send(REQ_READ,    16'h1234, 8'hFF, 1'b1);
        send(REQ_PROGRAM, 16'hFFFE, 8'h11, 1'b0);
        send(REQ_PROGRAM, 16'h0000, 8'h22, 1'b0);
        send(REQ_PROGRAM, 16'h0000, 8'hFF, 1'b1);
        // reads and programs interleaved within one open burst
        send(REQ_PROGRAM, 16'h4000, 8'h77, 1'b0);
        send(REQ_READ,    16'hFFFF, 8'h00, 1'b0);
        send(REQ_PROGRAM, 16'h0000, 8'h88, 1'b1);
        // erase closes the open read burst
        send(REQ_READ,         16'h1200, 8'h00, 1'b0);
        send(REQ_SECTOR_ERASE, 16'h1234, 8'hFF, 1'b0);
        send(REQ_READ,         16'h12FE, 8'h00, 1'b1);
        send(REQ_SECTOR_ERASE, 16'hFFFF, 8'h00, 1'b1);
        send(REQ_READ,         16'hFF00, 8'h00, 1'b1);
        send(REQ_CHIP_ERASE,   16'h4000, 8'h00, 1'b1);
        send(REQ_READ,         16'h4000, 8'h00, 1'b0);
        send(REQ_READ,         16'h0000, 8'h00, 1'b1);
        wait_drain();

        while (sent < N_ITEMS) begin
            if (sent >= QUIET_FROM) quiet = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                run_burst(REQ_PROGRAM, 1'b0, 1'b0);
            end else if (sel < 75) begin
                run_burst(REQ_READ, 1'b0, 1'b0);
            end else if (sel < 85) begin
                run_burst(REQ_READ, 1'b1, 1'b0);
            end else if (sel < 90) begin
                run_burst($urandom_range(0, 1) ? REQ_PROGRAM : REQ_READ, 1'b0, 1'b1);
            end else if (sel < 96) begin
                if (sector_count < SECTOR_CAP) begin
                    send(REQ_SECTOR_ERASE, pick_address(), t_byte'($urandom),
                         1'($urandom_range(0, 1)));
                    sector_count++;
                end
            end else if (sel < 98) begin
                send($urandom_range(0, 1) ? REQ_PROGRAM : REQ_READ, t_address'($urandom),
                     t_byte'($urandom), 1'($urandom_range(0, 1)));
            end else if (chip_count < CHIP_CAP && sent > 150) begin
                send(REQ_CHIP_ERASE, t_address'($urandom), t_byte'($urandom),
                     1'($urandom_range(0, 1)));
                chip_count++;
            end
            if (!drained_mid && sent >= 300) begin
                wait_drain();
                drained_mid = 1'b1;
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d reads, %0d programs, %0d sector erases, %0d chip erases",
                 sent, sb.n_read, sb.n_program, sb.n_sector, sb.n_chip);
        $display("Program page folds: %0d, read wraps at end of memory: %0d, errors: %0d",
                 sb.n_page_wraps, sb.n_read_wraps, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* nor_flash_array_model.f */
rtl/core/nfa_pkg.sv
rtl/core/nfa_req_if.sv
rtl/core/nfa_rsp_if.sv
rtl/core/nfa_ram.sv
rtl/core/nor_flash_array_model.sv
test/tb_nor_flash_array_model.sv
